/* rtl/s2bq_pkg.sv */
// Shared types, constants and codes for the space-to-batch requantizer.
// Used by s2bq_div and space_to_batch_requantize.
`default_nettype none

package s2bq_pkg;

  localparam int STORE_DEPTH_DEF = 65536;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_CNT_W = 4;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [2:0] REG_IN_BATCH      = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_IN_WIDTH      = 3'd2;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd3;
  localparam logic [2:0] REG_BLOCK_ROWS    = 3'd4;
  localparam logic [2:0] REG_BLOCK_COLS    = 3'd5;
  localparam logic [2:0] REG_PAD_ROWS_TOP  = 3'd6;
  localparam logic [2:0] REG_PAD_COLS_LEFT = 3'd7;

  localparam logic [7:0]  QUANT_POS_MAX = 8'h7f;
  localparam logic [7:0]  QUANT_NEG_MAX = 8'h80;
  localparam logic [15:0] QUANT_POS_LIM = 16'd127;
  localparam logic [15:0] QUANT_NEG_LIM = 16'd128;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BATCH_GO,
    ST_BATCH_WAIT,
    ST_BLOCK_GO,
    ST_BLOCK_WAIT,
    ST_BOUNDS,
    ST_LIN_A,
    ST_LIN_B,
    ST_LIN_C,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_RESULT
  } s2bq_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/s2bq_chan_if.sv */
// Valid/ready channels for input words and result words.
// Depends on nothing; used by space_to_batch_requantize.
`default_nettype none

interface s2bq_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [15:0]       load_address;
  logic signed [7:0] load_value;
  logic [9:0]        out_batch;
  logic [7:0]        out_row;
  logic [7:0]        out_col;
  logic [7:0]        out_channel;

  modport source (
    output valid, mode, load_address, load_value, out_batch, out_row, out_col, out_channel,
    input  ready
  );
  modport sink (
    input  valid, mode, load_address, load_value, out_batch, out_row, out_col, out_channel,
    output ready
  );
endinterface

interface s2bq_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] quantized;
  logic              is_padding;
  logic              saturated;
  logic              no_scale;
  logic [6:0]        max_level;

  modport source (
    output valid, quantized, is_padding, saturated, no_scale, max_level,
    input  ready
  );
  modport sink (
    input  valid, quantized, is_padding, saturated, no_scale, max_level,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/space_to_batch_requantize.sv */
// Space-to-batch gather with int8 requantization over a tensor store in RAM.
// Load and clear words complete on acceptance; mode 3 words are dropped.
// A read word's result waits on the shared 16-step divider, run up to three
// times, or twice when the word is padded or the maximum is zero.
// Input is held through a read; the next word waits until the result is loaded.
// Reset: sizes 1, paddings 0, maximum 0; store contents undefined until loaded.
`default_nettype none

module space_to_batch_requantize #(
  parameter int STORE_DEPTH = s2bq_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  s2bq_in_if.sink                                items,
  s2bq_out_if.source                             results,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [s2bq_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [s2bq_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [s2bq_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // configuration
  logic [4:0] in_batch;
  logic [8:0] in_height;
  logic [8:0] in_width;
  logic [8:0] channel_count;
  logic [3:0] block_rows;
  logic [3:0] block_cols;
  logic [2:0] pad_rows_top;
  logic [2:0] pad_cols_left;
  logic       cfg_wr;

  logic [4:0] nb;
  logic [8:0] nh;
  logic [8:0] nw;
  logic [8:0] nc;
  logic [3:0] br;
  logic [3:0] bc;

  // control
  s2bq_pkg::s2bq_state_t state;
  s2bq_pkg::s2bq_state_t state_next;
  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;
  logic                  ram_re;
  s2bq_pkg::div_req_t    div_req;
  s2bq_pkg::div_rsp_t    div_rsp;

  // state and read datapath
  logic [6:0]        running_max;
  logic [9:0]        ob;
  logic [7:0]        orow;
  logic [7:0]        ocol;
  logic [7:0]        och;
  logic [4:0]        src_b;
  logic [9:0]        shift;
  logic [9:0]        shift_h;
  logic [3:0]        shift_w;
  logic [8:0]        ih;
  logic [8:0]        iw;
  logic [ADDR_W-1:0] lin_acc;
  logic [ADDR_W-1:0] lin;
  logic [7:0]        rd_val;

  logic [7:0]  blk;
  logic [12:0] row;
  logic [12:0] col;
  logic        pad_hit;

  logic [7:0]  mag;
  logic [14:0] mag_scaled;
  logic [15:0] scale_num;
  logic [7:0]  scale_den;
  logic        q_sat;
  logic [7:0]  q_val;

  logic        res_pad;
  logic        res_nos;
  logic        res_sat;
  logic [7:0]  res_q;

  logic        out_valid;
  logic [7:0]  out_q;
  logic        out_pad;
  logic        out_sat;
  logic        out_nos;
  logic [6:0]  out_max;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_batch      <= 5'd1;
      in_height     <= 9'd1;
      in_width      <= 9'd1;
      channel_count <= 9'd1;
      block_rows    <= 4'd1;
      block_cols    <= 4'd1;
      pad_rows_top  <= 3'd0;
      pad_cols_left <= 3'd0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        s2bq_pkg::REG_IN_BATCH:      in_batch      <= pwdata[4:0];
        s2bq_pkg::REG_IN_HEIGHT:     in_height     <= pwdata[8:0];
        s2bq_pkg::REG_IN_WIDTH:      in_width      <= pwdata[8:0];
        s2bq_pkg::REG_CHANNEL_COUNT: channel_count <= pwdata[8:0];
        s2bq_pkg::REG_BLOCK_ROWS:    block_rows    <= pwdata[3:0];
        s2bq_pkg::REG_BLOCK_COLS:    block_cols    <= pwdata[3:0];
        s2bq_pkg::REG_PAD_ROWS_TOP:  pad_rows_top  <= pwdata[2:0];
        s2bq_pkg::REG_PAD_COLS_LEFT: pad_cols_left <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      s2bq_pkg::REG_IN_BATCH:      prdata = s2bq_pkg::APB_DATA_W'(in_batch);
      s2bq_pkg::REG_IN_HEIGHT:     prdata = s2bq_pkg::APB_DATA_W'(in_height);
      s2bq_pkg::REG_IN_WIDTH:      prdata = s2bq_pkg::APB_DATA_W'(in_width);
      s2bq_pkg::REG_CHANNEL_COUNT: prdata = s2bq_pkg::APB_DATA_W'(channel_count);
      s2bq_pkg::REG_BLOCK_ROWS:    prdata = s2bq_pkg::APB_DATA_W'(block_rows);
      s2bq_pkg::REG_BLOCK_COLS:    prdata = s2bq_pkg::APB_DATA_W'(block_cols);
      s2bq_pkg::REG_PAD_ROWS_TOP:  prdata = s2bq_pkg::APB_DATA_W'(pad_rows_top);
      s2bq_pkg::REG_PAD_COLS_LEFT: prdata = s2bq_pkg::APB_DATA_W'(pad_cols_left);
      default: ;
    endcase
  end

  // zero sizes act as one
  assign nb = (in_batch == '0) ? 5'd1 : in_batch;
  assign nh = (in_height == '0) ? 9'd1 : in_height;
  assign nw = (in_width == '0) ? 9'd1 : in_width;
  assign nc = (channel_count == '0) ? 9'd1 : channel_count;
  assign br = (block_rows == '0) ? 4'd1 : block_rows;
  assign bc = (block_cols == '0) ? 4'd1 : block_cols;

  // ---------------------------------------------------------------- store
  s2bq_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_accept && (items.mode == s2bq_pkg::MODE_LOAD)),
    .waddr (ADDR_W'(items.load_address)),
    .wdata (items.load_value),
    .re    (ram_re),
    .raddr (lin),
    .rdata (rd_val)
  );

  s2bq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------- arithmetic
  assign in_accept = items.valid & items.ready;
  assign out_free  = ~out_valid | results.ready;

  assign blk = 8'(br) * 8'(bc);
  assign row = 13'(orow) * 13'(br) + 13'(shift_h);
  assign col = 13'(ocol) * 13'(bc) + 13'(shift_w);

  assign pad_hit = (shift >= 10'(blk)) || (9'(och) >= nc)
                || (row < 13'(pad_rows_top))
                || (row >= 13'(pad_rows_top) + 13'(nh))
                || (col < 13'(pad_cols_left))
                || (col >= 13'(pad_cols_left) + 13'(nw));

  assign lin = lin_acc * ADDR_W'(nc) + ADDR_W'(och);

  assign mag        = rd_val[7] ? (8'd0 - rd_val) : rd_val;
  assign mag_scaled = 15'({mag, 7'd0}) - 15'(mag);
  assign scale_num  = 16'({mag_scaled, 1'b0}) + 16'(running_max);
  assign scale_den  = {running_max, 1'b0};

  always_comb begin
    if (rd_val[7]) begin
      q_sat = div_rsp.quot > s2bq_pkg::QUANT_NEG_LIM;
      q_val = q_sat ? s2bq_pkg::QUANT_NEG_MAX : 8'(16'd0 - div_rsp.quot);
    end else begin
      q_sat = div_rsp.quot > s2bq_pkg::QUANT_POS_LIM;
      q_val = q_sat ? s2bq_pkg::QUANT_POS_MAX : div_rsp.quot[7:0];
    end
  end

  // ---------------------------------------------------------------- state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s2bq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      s2bq_pkg::ST_IDLE: begin
        if (in_accept && (items.mode == s2bq_pkg::MODE_READ)) begin
          state_next = s2bq_pkg::ST_BATCH_GO;
        end
      end
      s2bq_pkg::ST_BATCH_GO: state_next = s2bq_pkg::ST_BATCH_WAIT;
      s2bq_pkg::ST_BATCH_WAIT: begin
        if (div_rsp.done) begin
          state_next = s2bq_pkg::ST_BLOCK_GO;
        end
      end
      s2bq_pkg::ST_BLOCK_GO: state_next = s2bq_pkg::ST_BLOCK_WAIT;
      s2bq_pkg::ST_BLOCK_WAIT: begin
        if (div_rsp.done) begin
          state_next = s2bq_pkg::ST_BOUNDS;
        end
      end
      s2bq_pkg::ST_BOUNDS: begin
        if (pad_hit || (running_max == '0)) begin
          state_next = s2bq_pkg::ST_RESULT;
        end else begin
          state_next = s2bq_pkg::ST_LIN_A;
        end
      end
      s2bq_pkg::ST_LIN_A:    state_next = s2bq_pkg::ST_LIN_B;
      s2bq_pkg::ST_LIN_B:    state_next = s2bq_pkg::ST_LIN_C;
      s2bq_pkg::ST_LIN_C:    state_next = s2bq_pkg::ST_SCALE_GO;
      s2bq_pkg::ST_SCALE_GO: state_next = s2bq_pkg::ST_SCALE_WAIT;
      s2bq_pkg::ST_SCALE_WAIT: begin
        if (div_rsp.done) begin
          state_next = s2bq_pkg::ST_RESULT;
        end
      end
      s2bq_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = s2bq_pkg::ST_IDLE;
        end
      end
      default: state_next = s2bq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    items.ready   = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    unique case (state)
      s2bq_pkg::ST_IDLE: items.ready = 1'b1;
      s2bq_pkg::ST_BATCH_GO: begin
        div_req.start = 1'b1;
        div_req.num   = s2bq_pkg::DIV_NUM_W'(ob);
        div_req.den   = s2bq_pkg::DIV_DEN_W'(nb);
      end
      s2bq_pkg::ST_BLOCK_GO: begin
        div_req.start = 1'b1;
        div_req.num   = s2bq_pkg::DIV_NUM_W'(shift);
        div_req.den   = s2bq_pkg::DIV_DEN_W'(bc);
      end
      s2bq_pkg::ST_LIN_C: ram_re = 1'b1;
      s2bq_pkg::ST_SCALE_GO: begin
        div_req.start = 1'b1;
        div_req.num   = scale_num;
        div_req.den   = scale_den;
      end
      s2bq_pkg::ST_RESULT: out_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (in_accept) begin
      if (items.mode == s2bq_pkg::MODE_CLEAR) begin
        running_max <= '0;
      end else if ((items.mode == s2bq_pkg::MODE_LOAD)
                   && (items.load_value > $signed({1'b0, running_max}))) begin
        running_max <= items.load_value[6:0];
      end
    end
  end

  // ---------------------------------------------------------------- read datapath
  always_ff @(posedge clk) begin
    unique case (state)
      s2bq_pkg::ST_IDLE: begin
        if (in_accept) begin
          ob   <= items.out_batch;
          orow <= items.out_row;
          ocol <= items.out_col;
          och  <= items.out_channel;
        end
      end
      s2bq_pkg::ST_BATCH_WAIT: begin
        if (div_rsp.done) begin
          shift <= div_rsp.quot[9:0];
          src_b <= div_rsp.rem[4:0];
        end
      end
      s2bq_pkg::ST_BLOCK_WAIT: begin
        if (div_rsp.done) begin
          shift_h <= div_rsp.quot[9:0];
          shift_w <= div_rsp.rem[3:0];
        end
      end
      s2bq_pkg::ST_BOUNDS: begin
        ih      <= 9'(row - 13'(pad_rows_top));
        iw      <= 9'(col - 13'(pad_cols_left));
        res_pad <= pad_hit;
        res_nos <= ~pad_hit & (running_max == '0);
        res_sat <= 1'b0;
        res_q   <= '0;
      end
      s2bq_pkg::ST_LIN_A: lin_acc <= ADDR_W'(src_b) * ADDR_W'(nh) + ADDR_W'(ih);
      s2bq_pkg::ST_LIN_B: lin_acc <= lin_acc * ADDR_W'(nw) + ADDR_W'(iw);
      s2bq_pkg::ST_SCALE_WAIT: begin
        if (div_rsp.done) begin
          res_q   <= q_val;
          res_sat <= q_sat;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q   <= res_q;
      out_pad <= res_pad;
      out_sat <= res_sat;
      out_nos <= res_nos;
      out_max <= running_max;
    end
  end

  assign results.valid      = out_valid;
  assign results.quantized  = out_q;
  assign results.is_padding = out_pad;
  assign results.saturated  = out_sat;
  assign results.no_scale   = out_nos;
  assign results.max_level  = out_max;

  // ---------------------------------------------------------------- assertions
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == s2bq_pkg::ST_RESULT && out_valid && !results.ready)
      |=> (state == s2bq_pkg::ST_RESULT))
    else $error("finished result dropped while output register busy");

  a_read_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && items.mode == s2bq_pkg::MODE_READ) |=> (state == s2bq_pkg::ST_BATCH_GO))
    else $error("accepted read did not start division");

  a_max_stable: assert property (@(posedge clk) disable iff (rst)
    (state != s2bq_pkg::ST_IDLE) |=> $stable(running_max))
    else $error("running maximum changed during a read");

  a_div_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == s2bq_pkg::ST_BATCH_WAIT || state == s2bq_pkg::ST_BLOCK_WAIT
                      || state == s2bq_pkg::ST_SCALE_WAIT))
    else $error("divider finished outside a wait state");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_pad && out_nos) && !(out_pad && out_sat) && !(out_nos && out_sat))
    else $error("conflicting result flags");

endmodule

`default_nettype wire

/* rtl/s2bq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module s2bq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/s2bq_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all read divisions.
// Depends on s2bq_pkg for widths and request/response structs.
`default_nettype none

module s2bq_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire s2bq_pkg::div_req_t req,
  output s2bq_pkg::div_rsp_t      rsp
);

  logic                           busy;
  logic                           done;
  logic [s2bq_pkg::DIV_CNT_W-1:0] cnt;
  logic [s2bq_pkg::DIV_NUM_W-1:0] num_sh;
  logic [s2bq_pkg::DIV_NUM_W-1:0] quot;
  logic [s2bq_pkg::DIV_DEN_W-1:0] den;
  logic [s2bq_pkg::DIV_DEN_W-1:0] rem;
  logic [s2bq_pkg::DIV_DEN_W:0]   trial;
  logic                           fits;

  assign trial = {rem, num_sh[s2bq_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.num;
      den    <= req.den;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      quot   <= {quot[s2bq_pkg::DIV_NUM_W-2:0], fits};
      rem    <= fits ? s2bq_pkg::DIV_DEN_W'(trial - {1'b0, den})
                     : trial[s2bq_pkg::DIV_DEN_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire
